// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the walker RTL.
// Clocked implication forms; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/fat12_pkg.sv =====
// Shared types and constants of the FAT12 cluster chain walker.
// No dependencies.
`default_nettype none

package fat12_pkg;

   localparam int TABLE_BYTES_DEFAULT = 8192;
   localparam int FIELD_ADDR_W        = 13;
   localparam int CLUSTER_W           = 12;
   localparam int SPC_W               = 8;
   localparam int LBA_W               = 32;
   localparam int PROD_W              = CLUSTER_W + SPC_W;

   localparam logic [CLUSTER_W-1:0] FAT_END       = 12'hff8;
   localparam logic [CLUSTER_W-1:0] CLUSTER_FIRST = 12'd2;
   localparam logic [SPC_W-1:0]     SPC_RESET     = 8'd1;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_START   = 2'd1;
   localparam logic [1:0] OP_ADVANCE = 2'd2;

   localparam logic [1:0] ST_MORE    = 2'd0;
   localparam logic [1:0] ST_LAST    = 2'd1;
   localparam logic [1:0] ST_INVALID = 2'd2;
   localparam logic [1:0] ST_NO_WALK = 2'd3;

   localparam logic CSR_DATA_START = 1'b0;
   localparam logic CSR_SPC        = 1'b1;

   typedef struct packed {
      logic capture;
      logic load;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_walk;
      logic is_load;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// ===== rtl/fat12_ram.sv =====
// Generic single-write, dual-read RAM with registered read data.
// No dependencies.
`default_nettype none

module fat12_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8192,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr_a,
   output logic      [WIDTH-1:0] rd_data_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic      [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem_ff[rd_addr_a];
      rd_data_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

`default_nettype wire

// ===== rtl/fat12_ctrl.sv =====
// Controller of the walker: accept, table read, emit sequencing.
// Depends on fat12_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fat12_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire fat12_pkg::status_type stat,
   output fat12_pkg::cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_READ = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd.capture = 1'b0;
      cmd.load    = 1'b0;
      cmd.emit    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load    = accept && stat.is_load;
            cmd.capture = accept && stat.is_walk;
            if (cmd.capture) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `ASSERT_NEXT(a_capture_reads, clock, reset, cmd.capture, state_ff == ST_READ)
   `ASSERT_NEXT(a_read_done, clock, reset, state_ff == ST_READ, state_ff == ST_DONE)

endmodule

`default_nettype wire

// ===== rtl/fat12_dp.sv =====
// Datapath of the walker: table RAM, walk state, sector math, result register.
// Depends on fat12_pkg, fat12_ram and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module fat12_dp #(
   parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEFAULT
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire fat12_pkg::cmd_type                   cmd,
   output fat12_pkg::status_type                     stat,
   input  wire logic [1:0]                           req_opcode,
   input  wire logic [fat12_pkg::FIELD_ADDR_W-1:0]   req_table_address,
   input  wire logic [7:0]                           req_table_byte,
   input  wire logic [fat12_pkg::CLUSTER_W-1:0]      req_start_cluster,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic      [fat12_pkg::LBA_W-1:0]          rsp_sector_lba,
   output logic      [fat12_pkg::CLUSTER_W-1:0]      rsp_cluster_number,
   output logic      [1:0]                           rsp_walk_status,
   input  wire logic                                 csr_write_enable,
   input  wire logic                                 csr_index,
   input  wire logic [fat12_pkg::LBA_W-1:0]          csr_write_data
);

   localparam int AW  = $clog2(TABLE_BYTES);
   localparam int CW  = fat12_pkg::CLUSTER_W;
   localparam int FW  = fat12_pkg::FIELD_ADDR_W;
   localparam int LW  = fat12_pkg::LBA_W;
   localparam int PW  = fat12_pkg::PROD_W;
   localparam logic [FW:0] LIMIT = (FW + 1)'(TABLE_BYTES);

   logic [LW-1:0]             ds_ff,  ds_in;
   logic [fat12_pkg::SPC_W-1:0] spc_ff, spc_in;
   logic          walk_active_ff, walk_active_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [CW-1:0] cl_ff;
   logic          item_active_ff;
   logic [PW-1:0] prod_ff;
   logic          ok0_ff, ok1_ff;
   logic [LW-1:0] lba_ff;
   logic [CW-1:0] num_ff;
   logic [1:0]    sts_ff;

   logic [FW-1:0] off0, off1;
   logic          ok0, ok1, wr_ok;
   logic [7:0]    rd0, rd1;
   logic [15:0]   pair;
   logic [CW-1:0] nxt;
   logic          cl_bad, chain_end, cont;
   logic [LW-1:0] lba;
   logic [1:0]    sts;
   logic [PW-1:0] prod;

   assign stat.is_load  = (req_opcode == fat12_pkg::OP_LOAD);
   assign stat.is_walk  = (req_opcode == fat12_pkg::OP_START) ||
                          (req_opcode == fat12_pkg::OP_ADVANCE);
   assign stat.out_free = !rsp_valid_ff || !rsp_stall;

   assign off0  = FW'(cl_ff) + FW'(cl_ff[CW-1:1]);
   assign off1  = off0 + FW'(1);
   assign ok0   = {1'b0, off0} < LIMIT;
   assign ok1   = {1'b0, off1} < LIMIT;
   assign wr_ok = {1'b0, req_table_address} < LIMIT;
   assign prod  = PW'(cl_ff - fat12_pkg::CLUSTER_FIRST) * PW'(spc_ff);

   fat12_ram #(
      .WIDTH (8),
      .DEPTH (TABLE_BYTES)
   ) u_table (
      .clock     (clock),
      .wr_en     (cmd.load && wr_ok),
      .wr_addr   (req_table_address[AW-1:0]),
      .wr_data   (req_table_byte),
      .rd_addr_a (off0[AW-1:0]),
      .rd_data_a (rd0),
      .rd_addr_b (off1[AW-1:0]),
      .rd_data_b (rd1)
   );

   assign pair      = {(ok1_ff ? rd1 : 8'd0), (ok0_ff ? rd0 : 8'd0)};
   assign nxt       = cl_ff[0] ? pair[15:4] : pair[11:0];
   assign cl_bad    = cl_ff < fat12_pkg::CLUSTER_FIRST;
   assign chain_end = nxt >= fat12_pkg::FAT_END;
   assign cont      = item_active_ff && !cl_bad && !chain_end;
   assign lba       = ds_ff + LW'(prod_ff);

   always_comb begin
      if (!item_active_ff) begin
         sts = fat12_pkg::ST_NO_WALK;
      end else if (cl_bad) begin
         sts = fat12_pkg::ST_INVALID;
      end else if (chain_end) begin
         sts = fat12_pkg::ST_LAST;
      end else begin
         sts = fat12_pkg::ST_MORE;
      end
   end

   always_comb begin
      ds_in          = ds_ff;
      spc_in         = spc_ff;
      walk_active_in = walk_active_ff;
      cur_in         = cur_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      if (csr_write_enable) begin
         case (csr_index)
            fat12_pkg::CSR_DATA_START: ds_in  = csr_write_data;
            fat12_pkg::CSR_SPC:        spc_in = csr_write_data[fat12_pkg::SPC_W-1:0];
            default:                   ds_in  = ds_ff;
         endcase
      end
      if (cmd.emit) begin
         rsp_valid_in   = 1'b1;
         walk_active_in = cont;
         if (cont) begin
            cur_in = nxt;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ds_ff          <= '0;
         spc_ff         <= fat12_pkg::SPC_RESET;
         walk_active_ff <= 1'b0;
         cur_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         ds_ff          <= ds_in;
         spc_ff         <= spc_in;
         walk_active_ff <= walk_active_in;
         cur_ff         <= cur_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ok0_ff  <= ok0;
      ok1_ff  <= ok1;
      prod_ff <= prod;
      if (cmd.capture) begin
         if (req_opcode == fat12_pkg::OP_START) begin
            cl_ff          <= req_start_cluster;
            item_active_ff <= 1'b1;
         end else begin
            cl_ff          <= cur_ff;
            item_active_ff <= walk_active_ff;
         end
      end
      if (cmd.emit) begin
         lba_ff <= (item_active_ff && !cl_bad) ? lba : '0;
         num_ff <= item_active_ff ? cl_ff : '0;
         sts_ff <= sts;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_sector_lba     = lba_ff;
   assign rsp_cluster_number = num_ff;
   assign rsp_walk_status    = sts_ff;

   `ASSERT_IMPL(a_emit_slot_free, clock, reset, cmd.emit, !rsp_valid_ff || !rsp_stall)
   `ASSERT_NEXT(a_emit_shows, clock, reset, cmd.emit, rsp_valid_ff)
   `ASSERT_NEXT(a_walk_holds, clock, reset, !cmd.emit, $stable(walk_active_ff))

endmodule

`default_nettype wire

// ===== rtl/fat12_cluster_chain_walker.sv =====
// A start or advance captures its cluster, reads the two table bytes into registers
// and then writes the result register once that register is free.
// Throughput: a walk item holds off new requests until its result is written;
// table loads one per cycle while no walk item is in flight.
// Reset (synchronous, active high) ends any walk, empties the result register
// and restores the control state and geometry registers; the table RAM keeps its contents.
`default_nettype none

module fat12_cluster_chain_walker #(
   parameter int TABLE_BYTES = fat12_pkg::TABLE_BYTES_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [1:0]                         req_opcode,
   input  wire logic [fat12_pkg::FIELD_ADDR_W-1:0] req_table_address,
   input  wire logic [7:0]                         req_table_byte,
   input  wire logic [fat12_pkg::CLUSTER_W-1:0]    req_start_cluster,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic      [fat12_pkg::LBA_W-1:0]        rsp_sector_lba,
   output logic      [fat12_pkg::CLUSTER_W-1:0]    rsp_cluster_number,
   output logic      [1:0]                         rsp_walk_status,
   input  wire logic                               csr_write_enable,
   input  wire logic                               csr_index,
   input  wire logic [fat12_pkg::LBA_W-1:0]        csr_write_data
);

   fat12_pkg::cmd_type    cmd;
   fat12_pkg::status_type stat;

   fat12_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   fat12_dp #(
      .TABLE_BYTES (TABLE_BYTES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .stat               (stat),
      .req_opcode         (req_opcode),
      .req_table_address  (req_table_address),
      .req_table_byte     (req_table_byte),
      .req_start_cluster  (req_start_cluster),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sector_lba     (rsp_sector_lba),
      .rsp_cluster_number (rsp_cluster_number),
      .rsp_walk_status    (rsp_walk_status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

endmodule

`default_nettype wire

// ===== dv/tb_fat12_cluster_chain_walker.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for fat12_cluster_chain_walker: loads a packed FAT12 table,
// walks chains under several geometry settings and checks every emitted cluster.
// Depends on fat12_pkg and the walker RTL.

module tb_fat12_cluster_chain_walker;

   localparam int         TABLE_SPAN    = fat12_pkg::TABLE_BYTES_DEFAULT;
   localparam int         AW            = fat12_pkg::FIELD_ADDR_W;
   localparam int         CW            = fat12_pkg::CLUSTER_W;
   localparam int         LW            = fat12_pkg::LBA_W;
   localparam int         SW            = fat12_pkg::SPC_W;
   localparam int         WALK_CLUSTERS = 256;
   localparam int         WALK_BYTES    = WALK_CLUSTERS * 3 / 2;
   localparam logic [1:0] OP_UNUSED     = 2'd3;
   localparam int         QUIET_LIMIT   = 4000;
   localparam int         MAX_REPORTS   = 10;

   typedef struct packed {
      logic [1:0]    opcode;
      logic [AW-1:0] table_address;
      logic [7:0]    table_byte;
      logic [CW-1:0] start_cluster;
   } walk_cmd_type;

   typedef struct packed {
      logic [LW-1:0] sector_lba;
      logic [CW-1:0] cluster_number;
      logic [1:0]    walk_status;
   } cluster_emit_type;

   logic             clock            = 1'b0;
   logic             reset            = 1'b1;
   logic             req_valid        = 1'b0;
   walk_cmd_type     req_cmd          = '0;
   logic             rsp_stall        = 1'b0;
   logic             csr_write_enable = 1'b0;
   logic             csr_index        = fat12_pkg::CSR_DATA_START;
   logic [LW-1:0]    csr_write_data   = '0;
   logic             req_stall;
   logic             rsp_valid;
   logic [LW-1:0]    rsp_sector_lba;
   logic [CW-1:0]    rsp_cluster_number;
   logic [1:0]       rsp_walk_status;

   walk_cmd_type     cmd_backlog [$];
   cluster_emit_type emits_due [$];
   cluster_emit_type predicted;
   cluster_emit_type wanted;
   int               failures     = 0;
   int               quiet_cycles = 0;
   logic             req_took     = 1'b0;
   int unsigned      req_gap      = 0;
   int unsigned      calm_req     = 0;
   int unsigned      rsp_hold     = 0;
   int unsigned      calm_rsp     = 0;

   logic [7:0]       fat_copy [0:TABLE_SPAN-1];
   logic [CW-1:0]    walk_cursor    = '0;
   logic             walk_live      = 1'b0;
   logic [LW-1:0]    geo_data_start = '0;
   logic [SW-1:0]    geo_spc        = fat12_pkg::SPC_RESET;

   fat12_cluster_chain_walker DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_cmd.opcode),
      .req_table_address  (req_cmd.table_address),
      .req_table_byte     (req_cmd.table_byte),
      .req_start_cluster  (req_cmd.start_cluster),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sector_lba     (rsp_sector_lba),
      .rsp_cluster_number (rsp_cluster_number),
      .rsp_walk_status    (rsp_walk_status),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int unsigned idle_span();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [7:0] fat_byte(input int unsigned addr);
      if (addr >= TABLE_SPAN) return 8'h00;
      return fat_copy[addr];
   endfunction

   function automatic logic [CW-1:0] fat_next(input logic [CW-1:0] cl);
      int unsigned cl_wide;
      int unsigned off;
      logic [15:0] pair;
      cl_wide = cl;
      off     = cl_wide * 3 / 2;
      pair    = {fat_byte(off + 1), fat_byte(off)};
      if (!cl[0]) return pair[11:0];
      return pair[15:4];
   endfunction

   function automatic bit walk_step(input walk_cmd_type c, output cluster_emit_type r);
      logic [CW-1:0] cl;
      logic [CW-1:0] nxt;
      logic [LW-1:0] span;
      r = '0;
      case (c.opcode)
         fat12_pkg::OP_LOAD: begin
            if (c.table_address < TABLE_SPAN) fat_copy[c.table_address] = c.table_byte;
            return 1'b0;
         end
         OP_UNUSED: return 1'b0;
         fat12_pkg::OP_START: begin
            walk_cursor = c.start_cluster;
            walk_live   = 1'b1;
         end
         default: ;
      endcase
      if (!walk_live) begin
         r.walk_status = fat12_pkg::ST_NO_WALK;
         return 1'b1;
      end
      cl               = walk_cursor;
      r.cluster_number = cl;
      if (cl < fat12_pkg::CLUSTER_FIRST) begin
         r.walk_status = fat12_pkg::ST_INVALID;
         walk_live     = 1'b0;
      end else begin
         span         = LW'(cl - fat12_pkg::CLUSTER_FIRST);
         r.sector_lba = geo_data_start + span * geo_spc;
         nxt          = fat_next(cl);
         if (nxt >= fat12_pkg::FAT_END) begin
            r.walk_status = fat12_pkg::ST_LAST;
            walk_live     = 1'b0;
         end else begin
            r.walk_status = fat12_pkg::ST_MORE;
            walk_cursor   = nxt;
         end
      end
      return 1'b1;
   endfunction

   function automatic logic [CW-1:0] chain_entry();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 75) return CW'($urandom_range(2, WALK_CLUSTERS - 1));
      if (roll < 93) return CW'($urandom_range(32'hff8, 32'hfff));
      return CW'($urandom_range(0, 1));
   endfunction

   function automatic void queue_walk(input logic [1:0] op, input logic [CW-1:0] cluster);
      walk_cmd_type c;
      c.opcode        = op;
      c.table_address = AW'($urandom);
      c.table_byte    = 8'($urandom);
      c.start_cluster = cluster;
      cmd_backlog.push_back(c);
   endfunction

   function automatic void queue_load(input logic [AW-1:0] addr, input logic [7:0] value);
      walk_cmd_type c;
      c.opcode        = fat12_pkg::OP_LOAD;
      c.table_address = addr;
      c.table_byte    = value;
      c.start_cluster = CW'($urandom);
      cmd_backlog.push_back(c);
   endfunction

   function automatic void queue_pair(input int k, input logic [CW-1:0] e0,
                                      input logic [CW-1:0] e1);
      queue_load(AW'(3 * k),     e0[7:0]);
      queue_load(AW'(3 * k + 1), {e1[3:0], e0[11:8]});
      queue_load(AW'(3 * k + 2), e1[11:4]);
   endfunction

   task automatic queue_random(input int count);
      int           made;
      int unsigned  roll;
      int unsigned  hops;
      walk_cmd_type raw;
      made = 0;
      while (made < count) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) begin
            if ($urandom_range(0, 19) == 0) begin
               queue_walk(fat12_pkg::OP_START, CW'($urandom_range(0, 1)));
            end else begin
               queue_walk(fat12_pkg::OP_START, CW'($urandom_range(2, WALK_CLUSTERS - 1)));
            end
            hops = $urandom_range(1, 8);
            repeat (hops) queue_walk(fat12_pkg::OP_ADVANCE, CW'($urandom));
            made += hops + 1;
         end else if (roll < 85) begin
            queue_pair($urandom_range(0, WALK_CLUSTERS / 2 - 1), chain_entry(), chain_entry());
            made += 3;
         end else if (roll < 93) begin
            queue_walk(fat12_pkg::OP_ADVANCE, CW'($urandom));
            made++;
         end else if (roll < 96) begin
            queue_walk(OP_UNUSED, CW'($urandom));
            made++;
         end else begin
            raw.opcode        = 2'($urandom);
            raw.table_address = AW'($urandom_range(WALK_BYTES, TABLE_SPAN - 1));
            raw.table_byte    = 8'($urandom);
            raw.start_cluster = CW'($urandom_range(0, WALK_CLUSTERS - 1));
            cmd_backlog.push_back(raw);
            made++;
         end
      end
   endtask

   task automatic program_geometry(input logic [LW-1:0] base, input logic [LW-1:0] spc_word);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= fat12_pkg::CSR_DATA_START;
      csr_write_data   <= base;
      @(negedge clock);
      csr_index        <= fat12_pkg::CSR_SPC;
      csr_write_data   <= spc_word;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic settle();
      while (cmd_backlog.size() != 0 || req_valid || emits_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the stalled transfer
      end else if (req_gap != 0) begin
         req_valid <= 1'b0;
         req_gap--;
      end else if (cmd_backlog.size() != 0) begin
         req_cmd   <= cmd_backlog.pop_front();
         req_valid <= 1'b1;
         if (calm_req != 0) begin
            calm_req--;
            req_gap = 0;
         end else begin
            req_gap = idle_span();
            if ($urandom_range(0, 39) == 0) calm_req = $urandom_range(30, 80);
         end
      end else begin
         req_valid <= 1'b0;
      end
   end

   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_stall <= 1'b1;
         rsp_hold--;
      end else begin
         rsp_stall <= 1'b0;
         if (calm_rsp != 0) calm_rsp--;
         else if ($urandom_range(0, 59) == 0) calm_rsp = $urandom_range(40, 150);
         else rsp_hold = idle_span();
      end
   end

   always @(posedge clock) begin
      req_took = 1'b0;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (emits_due.size() == 0) begin
               failures++;
               if (failures <= MAX_REPORTS)
                  $display("unexpected walk result: lba=%h cluster=%0d status=%0d",
                           rsp_sector_lba, rsp_cluster_number, rsp_walk_status);
            end else begin
               wanted = emits_due.pop_front();
               if (rsp_sector_lba !== wanted.sector_lba ||
                   rsp_cluster_number !== wanted.cluster_number ||
                   rsp_walk_status !== wanted.walk_status) begin
                  failures++;
                  if (failures <= MAX_REPORTS) begin
                     $display("walk result mismatch: expected lba=%h cluster=%0d status=%0d",
                              wanted.sector_lba, wanted.cluster_number, wanted.walk_status);
                     $display("                      got      lba=%h cluster=%0d status=%0d",
                              rsp_sector_lba, rsp_cluster_number, rsp_walk_status);
                  end
               end
            end
         end
         if (req_valid && !req_stall) begin
            req_took = 1'b1;
            if (walk_step(req_cmd, predicted)) emits_due.push_back(predicted);
         end
         if (csr_write_enable) begin
            case (csr_index)
               fat12_pkg::CSR_DATA_START: geo_data_start = csr_write_data;
               fat12_pkg::CSR_SPC:        geo_spc        = csr_write_data[SW-1:0];
               default: ;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable)
         quiet_cycles = 0;
      else
         quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_fat12_cluster_chain_walker NOT OK");
         $finish;
      end
   end

   initial begin
      logic [CW-1:0] chain_map [0:4095];
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int i = 0; i < 4096; i++) begin
         chain_map[i] = chain_entry();
      end
      chain_map[2]    = 12'd3;
      chain_map[3]    = 12'd4;
      chain_map[4]    = fat12_pkg::FAT_END;
      chain_map[5]    = 12'hfff;
      chain_map[6]    = 12'd1;
      chain_map[7]    = 12'hff7;
      chain_map[4087] = 12'hfff;
      chain_map[4095] = 12'd2;
      // pack two entries into three bytes, covering every reachable offset
      for (int k = 0; k < WALK_CLUSTERS / 2; k++) begin
         queue_pair(k, chain_map[2 * k], chain_map[2 * k + 1]);
      end
      queue_pair(2043, chain_map[4086], chain_map[4087]);
      queue_pair(2047, chain_map[4094], chain_map[4095]);

      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_walk(fat12_pkg::OP_START,   12'd0);
      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_walk(fat12_pkg::OP_START,   12'd1);
      queue_walk(fat12_pkg::OP_START,   12'd2);
      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_walk(OP_UNUSED,             12'd0);
      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_walk(fat12_pkg::OP_START,   12'd5);
      queue_walk(fat12_pkg::OP_START,   12'd6);
      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_walk(fat12_pkg::OP_START,   12'd7);
      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_walk(fat12_pkg::OP_START,   12'hfff);
      queue_walk(fat12_pkg::OP_START,   12'd3);
      queue_walk(fat12_pkg::OP_ADVANCE, 12'd0);
      queue_load(13'h1fff, 8'hff);
      queue_load(13'h1fff, 8'h00);
      queue_load(13'h0000, 8'hff);
      settle();

      program_geometry(32'hffff_ffff, 32'd128);
      queue_random(260);
      settle();
      program_geometry(32'd0, 32'd1);
      queue_random(260);
      settle();
      program_geometry($urandom, $urandom_range(1, 128));
      queue_random(260);
      settle();
      program_geometry($urandom, $urandom & 32'hffff_ff00);
      queue_random(260);
      settle();
      program_geometry($urandom, 32'h0000_00ff);
      queue_random(260);
      settle();

      if (failures == 0) $display("tb_fat12_cluster_chain_walker OK");
      else $display("tb_fat12_cluster_chain_walker NOT OK");
      $finish;
   end

endmodule
